[sv/timed_valve_positioner_defines.svh]
// ----------------------------------------------------------------------------
// Timed valve positioner assertion macros
// Shared property forms for the checker of the valve positioner ports.
// ----------------------------------------------------------------------------
`ifndef TIMED_VALVE_POSITIONER_DEFINES_SVH
`define TIMED_VALVE_POSITIONER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tvp_pkg.sv]
// ----------------------------------------------------------------------------
// Timed valve positioner package
// Shared types, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package tvp_pkg;

  // Default widths of the battery sample and of all millisecond times.
  localparam int ADC_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF = 14;

  // Fixed field widths.
  localparam int KNOB_W      = 7;
  localparam int SLOPE_W     = 13;
  localparam int DB_W        = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 8;

  // Percent full scale used for the open time.
  localparam int PCT_FULL = 100;

  // Close time rounding: Q8 fraction with half-up rounding.
  localparam int Q_FRAC = 8;
  localparam int Q_HALF = 128;

  // Register reset values.
  localparam int MIN_BAT_RST = 546;
  localparam int SLOPE_RST   = -1406;
  localparam int OFFSET_RST  = 8650;
  localparam int TIMEOUT_RST = 5000;
  localparam int DB_RST      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BATTERY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd4;

  // Valve phase codes.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CLOSE = 2'd1,
    PH_OPEN  = 2'd2
  } phase_t;

  // Controller sequencing states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_S,
    ST_CT,
    ST_MUL_T,
    ST_RECIP,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic closing;
  } sts_t;

  // Width of the configuration data bus: the widest register.
  function automatic int cfg_w(input int adc_bits, input int time_bits);
    int w;
    w = SLOPE_W;
    if (adc_bits > w) w = adc_bits;
    if (time_bits > w) w = time_bits;
    return w;
  endfunction

endpackage

[sv/tvp_ctrl.sv]
// ----------------------------------------------------------------------------
// Timed valve positioner controller
// Sequences one request at a time, through the close time multiply chain when
// closing, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tvp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tvp_pkg::sts_t sts,
  output tvp_pkg::cmd_t cmd
);

  tvp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      tvp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // Only a closing tick needs the close time and open time chain.
          state_nxt = sts.closing ? tvp_pkg::ST_MUL_S : tvp_pkg::ST_COMMIT;
        end
      end
      tvp_pkg::ST_MUL_S: state_nxt = tvp_pkg::ST_CT;
      tvp_pkg::ST_CT:    state_nxt = tvp_pkg::ST_MUL_T;
      tvp_pkg::ST_MUL_T: state_nxt = tvp_pkg::ST_RECIP;
      tvp_pkg::ST_RECIP: state_nxt = tvp_pkg::ST_COMMIT;
      tvp_pkg::ST_COMMIT: begin
        // Wait for the output register to be free before updating state.
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tvp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tvp_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

[sv/tvp_dp.sv]
// ----------------------------------------------------------------------------
// Timed valve positioner datapath
// Configuration registers, close time and open time arithmetic, the valve
// state and the result register.
// ----------------------------------------------------------------------------
module tvp_dp #(
  parameter int ADC_BITS  = tvp_pkg::ADC_BITS_DEF,
  parameter int TIME_BITS = tvp_pkg::TIME_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [tvp_pkg::cfg_w(ADC_BITS, TIME_BITS)-1:0] cfg_data,
  input  logic [tvp_pkg::KNOB_W-1:0]                knob_position,
  input  logic [ADC_BITS-1:0]                       battery_code,
  input  tvp_pkg::cmd_t                             cmd,
  output tvp_pkg::sts_t                             sts,
  output logic                                      valve_drive,
  output logic                                      relay_close,
  output tvp_pkg::phase_t                           phase
);

  // Product of slope and battery code, with room for the sign.
  localparam int PW  = tvp_pkg::SLOPE_W + ADC_BITS + 1;
  localparam int PW1 = PW + 1;
  // Close time times target, and its reciprocal multiply for the divide.
  localparam int XW  = TIME_BITS + tvp_pkg::KNOB_W;
  localparam int SH  = XW + 7;
  localparam int MW  = XW + 1;
  localparam int YW  = XW + MW;
  localparam int QW  = YW - SH;
  localparam longint unsigned RECIP_L = (64'd1 << SH) / tvp_pkg::PCT_FULL + 1;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP_L);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration registers.
  logic        [ADC_BITS-1:0]        min_bat_r;
  logic signed [tvp_pkg::SLOPE_W-1:0] slope_r;
  logic        [TIME_BITS-1:0]       offset_r;
  logic        [TIME_BITS-1:0]       timeout_r;
  logic        [tvp_pkg::DB_W-1:0]   deadband_r;

  // Captured request and arithmetic pipeline.
  logic        [tvp_pkg::KNOB_W-1:0] knob_r;
  logic        [ADC_BITS-1:0]        code_r;
  logic signed [PW-1:0]              p_r;
  logic        [TIME_BITS-1:0]       ct_r, ct_nxt;
  logic        [XW-1:0]              x_r;
  logic        [YW-1:0]              y_r;

  // Valve state.
  tvp_pkg::phase_t                   phase_r, phase_nxt;
  logic        [tvp_pkg::KNOB_W-1:0] target_r, target_nxt;
  logic        [TIME_BITS-1:0]       elapsed_r, elapsed_nxt;
  logic        [TIME_BITS-1:0]       od_r, od_nxt;
  logic                              relay_r, relay_nxt;

  // Result register.
  logic                              out_valve_r, out_relay_r;
  tvp_pkg::phase_t                   out_phase_r;

  // Close time intermediate terms.
  logic signed [PW:0]                v_w, t_w;
  logic        [QW-1:0]              q_div;
  logic        [TIME_BITS-1:0]       od_sat, lim, el_inc;
  logic        [tvp_pkg::KNOB_W-1:0] diff;
  logic                              moved;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bat_r  <= ADC_BITS'(tvp_pkg::MIN_BAT_RST);
      slope_r    <= tvp_pkg::SLOPE_W'(tvp_pkg::SLOPE_RST);
      offset_r   <= TIME_BITS'(tvp_pkg::OFFSET_RST);
      timeout_r  <= TIME_BITS'(tvp_pkg::TIMEOUT_RST);
      deadband_r <= tvp_pkg::DB_W'(tvp_pkg::DB_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tvp_pkg::CFG_MIN_BATTERY: min_bat_r  <= cfg_data[ADC_BITS-1:0];
        tvp_pkg::CFG_SLOPE:       slope_r    <= cfg_data[tvp_pkg::SLOPE_W-1:0];
        tvp_pkg::CFG_OFFSET:      offset_r   <= cfg_data[TIME_BITS-1:0];
        tvp_pkg::CFG_TIMEOUT:     timeout_r  <= cfg_data[TIME_BITS-1:0];
        tvp_pkg::CFG_DEADBAND:    deadband_r <= cfg_data[tvp_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Close time: offset plus slope times code in Q8, rounded half up, clamped.
  always_comb begin
    v_w = PW1'(p_r) + PW1'(tvp_pkg::Q_HALF);
    t_w = PW1'($signed({1'b0, offset_r})) + (v_w >>> tvp_pkg::Q_FRAC);
    if (t_w[PW]) begin
      ct_nxt = '0;
    end else if (t_w > $signed(PW1'(TIME_MAX))) begin
      ct_nxt = TIME_MAX;
    end else begin
      ct_nxt = t_w[TIME_BITS-1:0];
    end
  end

  // Arithmetic pipeline: slope multiply, clamp, target multiply, reciprocal.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      knob_r <= knob_position;
      code_r <= battery_code;
    end
    p_r  <= PW'(slope_r) * PW'($signed({1'b0, code_r}));
    ct_r <= ct_nxt;
    x_r  <= XW'(ct_r) * XW'(target_r);
    y_r  <= YW'(x_r) * YW'(RECIP_M);
  end

  // Open time is the quotient by one hundred, saturated.
  assign q_div  = y_r[YW-1:SH];
  assign od_sat = (q_div > QW'(TIME_MAX)) ? TIME_MAX : q_div[TIME_BITS-1:0];
  assign lim    = (timeout_r < ct_r) ? timeout_r : ct_r;
  assign el_inc = (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign diff   = (knob_r > target_r) ? knob_r - target_r : target_r - knob_r;
  assign moved  = diff > deadband_r;

  // Valve state update for one tick.
  always_comb begin
    phase_nxt   = phase_r;
    target_nxt  = target_r;
    elapsed_nxt = elapsed_r;
    od_nxt      = od_r;
    relay_nxt   = relay_r;
    unique case (phase_r)
      tvp_pkg::PH_CLOSE: begin
        if (moved) begin
          // A knob move while closing restarts the close timer.
          target_nxt  = knob_r;
          elapsed_nxt = '0;
        end else if (el_inc >= lim) begin
          od_nxt      = od_sat;
          elapsed_nxt = '0;
          relay_nxt   = 1'b0;
          phase_nxt   = (od_sat == '0) ? tvp_pkg::PH_IDLE : tvp_pkg::PH_OPEN;
        end else begin
          elapsed_nxt = el_inc;
        end
      end
      tvp_pkg::PH_OPEN: begin
        elapsed_nxt = el_inc;
        if (el_inc >= od_r) phase_nxt = tvp_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = tvp_pkg::PH_IDLE;
        if (code_r > min_bat_r && moved) begin
          target_nxt  = knob_r;
          elapsed_nxt = '0;
          relay_nxt   = 1'b1;
          phase_nxt   = tvp_pkg::PH_CLOSE;
        end
      end
    endcase
  end

  // Valve state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tvp_pkg::PH_IDLE;
      target_r  <= '0;
      elapsed_r <= '0;
      od_r      <= '0;
      relay_r   <= 1'b0;
    end else if (cmd.commit) begin
      phase_r   <= phase_nxt;
      target_r  <= target_nxt;
      elapsed_r <= elapsed_nxt;
      od_r      <= od_nxt;
      relay_r   <= relay_nxt;
    end
  end

  // Result register shows the state after the tick.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_valve_r <= (phase_nxt != tvp_pkg::PH_IDLE);
      out_relay_r <= relay_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign sts.closing = (phase_r == tvp_pkg::PH_CLOSE);
  assign valve_drive = out_valve_r;
  assign relay_close = out_relay_r;
  assign phase       = out_phase_r;

endmodule

[sv/timed_valve_positioner.sv]
// Sequencing: while closing, an accepted request passes the slope multiply, close
// time clamp, target multiply and divide by 100 multiply before its commit; while
// idle or opening it goes straight to commit. A commit waits while a result is
// stalled at the output, and a new request is taken only after the commit.
// Reset: synchronous active-low rst_n sets the valve idle, target and timers to
// zero, relay off, output empty and the configuration registers to their reset values.
// ----------------------------------------------------------------------------
// Timed valve positioner
// Per millisecond tick, decides valve closing and opening from knob and
// battery samples with a battery-compensated close time.
// ----------------------------------------------------------------------------
module timed_valve_positioner #(
  parameter int ADC_BITS  = tvp_pkg::ADC_BITS_DEF,
  parameter int TIME_BITS = tvp_pkg::TIME_BITS_DEF,
  localparam int IN_W  = ((tvp_pkg::KNOB_W + ADC_BITS + 7) / 8) * 8,
  localparam int CFG_W = tvp_pkg::cfg_w(ADC_BITS, TIME_BITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // knob_position, battery_code, zero pad
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tvp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // valve_drive, relay_close, phase, zero pad
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data
);

  tvp_pkg::cmd_t   cmd;
  tvp_pkg::sts_t   sts;
  logic            valve_drive, relay_close;
  tvp_pkg::phase_t phase;

  tvp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tvp_dp #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .knob_position (in_tdata[tvp_pkg::KNOB_W-1:0]),
    .battery_code  (in_tdata[tvp_pkg::KNOB_W +: ADC_BITS]),
    .cmd           (cmd),
    .sts           (sts),
    .valve_drive   (valve_drive),
    .relay_close   (relay_close),
    .phase         (phase)
  );

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  // Pack the result fields from bit 0 up.
  assign out_tdata = {4'b0000, phase, relay_close, valve_drive};

endmodule

[sv/tvp_chk.sv]
// ----------------------------------------------------------------------------
// Timed valve positioner port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "timed_valve_positioner_defines.svh"

module tvp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tvp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic       in_take;
  logic       out_stall;
  logic       res_drive;
  logic       res_relay;
  logic [1:0] res_phase;
  logic       res_busy;
  logic       res_closing;
  logic       res_shown;

  // Handshake and result field views.
  assign in_take     = in_tvalid && in_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign res_drive   = out_tdata[0];
  assign res_relay   = out_tdata[1];
  assign res_phase   = out_tdata[3:2];
  assign res_busy    = (res_phase != tvp_pkg::PH_IDLE);
  assign res_closing = (res_phase == tvp_pkg::PH_CLOSE);
  assign res_shown   = out_tvalid && res_busy;

  // A pending result stays until taken.
  `TVP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid, "result dropped")

  // One request at a time: no request is taken right after another.
  `TVP_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_take, !in_tready, "taken while busy")

  // The drive is on exactly when the phase is not idle.
  `TVP_ASSERT_NOW(a_drive_phase, clk, rst_n, out_tvalid, res_drive == res_busy, "bad drive")

  // While driven, the relay shows closing exactly in the closing phase.
  `TVP_ASSERT_NOW(a_relay_phase, clk, rst_n, res_shown, res_relay == res_closing, "bad relay")

endmodule

bind timed_valve_positioner tvp_chk u_tvp_chk (.*);

[verif/timed_valve_positioner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed valve positioner testbench
// Streams millisecond tick requests into the positioner and checks every
// result against a cycle-free model of the close and open sequencing. The run
// steps through several register settings and idling patterns, with one long
// result back-pressure stretch.
// ----------------------------------------------------------------------------
module timed_valve_positioner_tb;
  import tvp_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam int TIME_W = TIME_BITS_DEF;
  localparam int IN_W = ((KNOB_W + ADC_W + 7) / 8) * 8;
  localparam int CFG_W = cfg_w(ADC_W, TIME_W);
  localparam int TIME_MAX = (1 << TIME_W) - 1;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 500000;

  // One tick request and one expected result.
  typedef struct packed {
    logic [ADC_W-1:0]  battery;
    logic [KNOB_W-1:0] knob;
  } tick_t;

  typedef struct packed {
    logic       valve_drive;
    logic       relay_close;
    logic [1:0] phase;
  } valve_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;       // knob_position, battery_code, zero pad
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // valve_drive, relay_close, phase, zero pad
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Request and result queues.
  tick_t         pending_ticks[$];
  valve_result_t expected_outputs[$];

  // Register copy, starting from the reset values.
  int battery_floor = MIN_BAT_RST;
  int close_slope = SLOPE_RST;
  int close_offset = OFFSET_RST;
  int close_timeout = TIMEOUT_RST;
  int dead_zone = DB_RST;

  // Valve state copy.
  phase_t              valve_phase = PH_IDLE;
  logic [KNOB_W-1:0]   valve_target = '0;
  logic [TIME_W-1:0]   valve_elapsed = '0;
  logic [TIME_W-1:0]   open_span = '0;
  logic                relay_dir = 1'b0;

  // Idling controls and bookkeeping.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_cycles_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  timed_valve_positioner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Battery-compensated close time: Q8 slope rounded half up, then clamped.
  function automatic int close_time_ms(input logic [ADC_W-1:0] code);
    int code_v;
    int frac_q;
    int t;
    code_v = code;
    frac_q = (close_slope * code_v + Q_HALF) >>> Q_FRAC;
    t = close_offset + frac_q;
    if (t < 0) t = 0;
    if (t > TIME_MAX) t = TIME_MAX;
    return t;
  endfunction

  function automatic bit knob_moved(input logic [KNOB_W-1:0] knob);
    int kv;
    int tv;
    int d;
    kv = knob;
    tv = valve_target;
    d = (kv > tv) ? kv - tv : tv - kv;
    return d > dead_zone;
  endfunction

  // Advances the valve state by one tick and queues the result it shows.
  function automatic void advance_valve(input logic [KNOB_W-1:0] knob,
                                        input logic [ADC_W-1:0] code);
    int ct;
    int lim;
    int span;
    int code_v;
    valve_result_t res;
    code_v = code;
    case (valve_phase)
      PH_CLOSE: begin
        if (knob_moved(knob)) begin
          valve_target = knob;
          valve_elapsed = '0;
        end else begin
          ct = close_time_ms(code);
          lim = (close_timeout < ct) ? close_timeout : ct;
          if (valve_elapsed != TIME_MAX) valve_elapsed = valve_elapsed + 1'b1;
          if (int'(valve_elapsed) >= lim) begin
            span = ct * int'(valve_target) / PCT_FULL;
            if (span > TIME_MAX) span = TIME_MAX;
            open_span = span[TIME_W-1:0];
            valve_elapsed = '0;
            relay_dir = 1'b0;
            valve_phase = (open_span == 0) ? PH_IDLE : PH_OPEN;
          end
        end
      end
      PH_OPEN: begin
        // Knob and battery are ignored while opening.
        if (valve_elapsed != TIME_MAX) valve_elapsed = valve_elapsed + 1'b1;
        if (valve_elapsed >= open_span) valve_phase = PH_IDLE;
      end
      default: begin
        valve_phase = PH_IDLE;
        if (code_v > battery_floor && knob_moved(knob)) begin
          valve_target = knob;
          valve_elapsed = '0;
          relay_dir = 1'b1;
          valve_phase = PH_CLOSE;
        end
      end
    endcase
    res.valve_drive = (valve_phase != PH_IDLE);
    res.relay_close = relay_dir;
    res.phase = valve_phase;
    expected_outputs.push_back(res);
  endfunction

  // Request driver: holds a request until accepted, models it on acceptance.
  always @(posedge clk) begin : tick_driver
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_valve(in_tdata[KNOB_W-1:0], in_tdata[KNOB_W +: ADC_W]);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = pending_ticks.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_W - KNOB_W - ADC_W){1'b0}}, nxt};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string field, input logic [1:0] want,
                               input logic [1:0] got);
    $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
    error_count++;
  endtask

  // Long result hold-off, counted down in cycles once requested.
  always @(posedge clk) begin : long_hold_counter
    if (!rst_n) begin
      hold_cycles_left <= 0;
    end else if (hold_cycles_left > 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_cycles_left <= LONG_HOLD;
    end
  end

  // Result monitor: compares each result with the oldest expectation and
  // drives the result back-pressure, holding off during the long stretch.
  always @(posedge clk) begin : result_monitor
    valve_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, actual %b", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_tdata[0] !== want.valve_drive)
            flag_mismatch("valve_drive", want.valve_drive, out_tdata[0]);
          if (out_tdata[1] !== want.relay_close)
            flag_mismatch("relay_close", want.relay_close, out_tdata[1]);
          if (out_tdata[3:2] !== want.phase)
            flag_mismatch("phase", want.phase, out_tdata[3:2]);
        end
      end
      if (hold_cycles_left > 0 || (long_hold_req && !long_hold_done)) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_tick(input int knob, input int code);
    pending_ticks.push_back('{battery: code[ADC_W-1:0], knob: knob[KNOB_W-1:0]});
  endtask

  // Checked between edges so that the driver's updates have settled.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_tvalid || expected_outputs.size() != 0)
      @(negedge clk);
  endtask

  // Feeds holding ticks until the valve is back at rest.
  task automatic settle_valve(input int code);
    wait_drained();
    while (valve_phase != PH_IDLE) begin
      queue_tick(valve_target, code);
      wait_drained();
    end
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_BATTERY: battery_floor = value[ADC_W-1:0];
      CFG_SLOPE:       close_slope = $signed(value[SLOPE_W-1:0]);
      CFG_OFFSET:      close_offset = value[TIME_W-1:0];
      CFG_TIMEOUT:     close_timeout = value[TIME_W-1:0];
      CFG_DEADBAND:    dead_zone = value[DB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_valve(input int floor_code, input int slope, input int offs,
                               input int limit_ms, input int band);
    write_setting(CFG_MIN_BATTERY, floor_code);
    write_setting(CFG_SLOPE, slope);
    write_setting(CFG_OFFSET, offs);
    write_setting(CFG_TIMEOUT, limit_ms);
    write_setting(CFG_DEADBAND, band);
  endtask

  // Mostly repositioning sessions: a knob step beyond the deadband followed by
  // a run of ticks that jitter within it, with an occasional fresh move. The
  // rest are stray requests.
  task automatic queue_valve_session(input int n_items, input int band_lo, input int band_hi,
                                     input int noise_lo, input int noise_hi,
                                     input int run_max);
    int left;
    int aim;
    int k;
    int run;
    int tries;
    left = n_items;
    aim = valve_target;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        tries = 0;
        do begin
          k = $urandom_range(0, 127);
          tries++;
        end while (((k > aim) ? k - aim : aim - k) <= dead_zone && tries < 20);
        aim = k;
        queue_tick(k, $urandom_range(band_lo, band_hi));
        left--;
        run = $urandom_range(1, run_max);
        while (run > 0 && left > 0) begin
          if ($urandom_range(0, 19) == 0) begin
            aim = $urandom_range(0, 127);
            k = aim;
          end else begin
            k = aim + $urandom_range(0, 2 * dead_zone) - dead_zone;
            if (k < 0) k = 0;
            if (k > 127) k = 127;
          end
          queue_tick(k, $urandom_range(band_lo, band_hi));
          run--;
          left--;
        end
      end else begin
        queue_tick($urandom_range(0, 127), $urandom_range(noise_lo, noise_hi));
        left--;
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: battery exactly at the floor, knob step equal to the
    // deadband, both field extremes; none of these may start a move.
    queue_tick(100, 546);
    queue_tick(127, 0);
    queue_tick(2, 1023);
    queue_tick(0, 547);
    settle_valve(0);

    // Short fixed close time with a four tick timeout.
    program_valve(100, 0, 10, 4, 2);
    queue_tick(3, 1023);
    queue_tick(5, 101);
    // A knob move while closing restarts the timer, battery at the floor.
    queue_tick(6, 100);
    queue_tick(6, 0);
    queue_tick(7, 0);
    queue_tick(8, 0);
    // Timeout reached with a zero open time: straight back to idle.
    queue_tick(4, 0);
    repeat (5) queue_tick(100, 1023);
    // Opening ignores the knob and the battery.
    queue_tick(0, 0);
    queue_tick(127, 512);
    queue_tick(64, 1023);
    settle_valve(1023);

    // Most negative slope: the close time clamps to zero.
    sender_idle_pct = 50;
    program_valve(0, -4096, 0, 0, 0);
    queue_valve_session(40, 1, 1023, 0, 1023, 4);
    settle_valve(1023);

    // No idling, short constant close time, longest timeout.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    program_valve(0, 0, 8, 16383, 0);
    queue_valve_session(150, 0, 1023, 0, 1023, 30);
    settle_valve(1023);

    // Highest battery floor: nothing may move.
    sender_idle_pct = 50;
    receiver_stall_pct = 50;
    program_valve(1023, 4095, 16383, 16383, 100);
    queue_valve_session(20, 0, 1023, 0, 1023, 5);
    settle_valve(1023);

    // Wide deadband with a steep negative slope near full battery.
    sender_idle_pct = 0;
    receiver_stall_pct = 50;
    program_valve(512, -4096, 16383, 12, 100);
    queue_valve_session(100, 1020, 1023, 1020, 1023, 100);
    settle_valve(1023);

    // Steepest positive slope with a long result hold-off.
    sender_idle_pct = 17;
    receiver_stall_pct = 17;
    program_valve(0, 4095, 0, 16383, 5);
    queue_valve_session(150, 0, 4, 0, 4, 90);
    long_hold_req = 1'b1;
    settle_valve(4);

    // Zero timeout: closing ends on the first later tick without a knob move.
    sender_idle_pct = 50;
    receiver_stall_pct = 0;
    program_valve(200, -2000, 1700, 0, 10);
    queue_valve_session(100, 205, 240, 205, 240, 140);
    settle_valve(240);

    // Small positive slope with fractional rounding.
    sender_idle_pct = 0;
    receiver_stall_pct = 50;
    program_valve(50, 300, 2, 7, 3);
    queue_valve_session(100, 51, 60, 51, 60, 100);
    settle_valve(60);

    wait_drained();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
